[sv/fcbb_pkg.sv]
// ----------------------------------------------------------------------------
// fcbb_pkg
// Shared types and constants of the frame change bounding box block.
// ----------------------------------------------------------------------------
package fcbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS  = X_BITS + Y_BITS;
  localparam int SIZE_BITS  = 11;
  localparam int PIX_BITS   = 24;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(640);
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(480);
  localparam logic [SIZE_BITS-1:0] MAX_W_SIZE   = SIZE_BITS'(MAX_WIDTH);
  localparam logic [SIZE_BITS-1:0] MAX_H_SIZE   = SIZE_BITS'(MAX_HEIGHT);

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [PIX_BITS-1:0]  data;
  } store_wr_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
  } store_rd_t;

  typedef struct packed {
    logic                 changed;
    logic [X_BITS-1:0]    region_x;
    logic [Y_BITS-1:0]    region_y;
    logic [SIZE_BITS-1:0] region_width;
    logic [SIZE_BITS-1:0] region_height;
  } result_t;

  function automatic logic [SIZE_BITS-1:0] clamp_size(
    input logic [SIZE_BITS-1:0] v,
    input logic [SIZE_BITS-1:0] maxv
  );
    logic [SIZE_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_BITS'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

[sv/fcbb_frame_store.sv]
// ----------------------------------------------------------------------------
// fcbb_frame_store
// Previous-frame pixel store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcbb_frame_store (
  input  logic                                 clk,
  input  fcbb_pkg::store_rd_t                  rd,
  input  fcbb_pkg::store_wr_t                  wr,
  output logic [fcbb_pkg::PIX_BITS-1:0]        rd_data
);

  localparam int DEPTH = 1 << fcbb_pkg::ADDR_BITS;

  logic [fcbb_pkg::PIX_BITS-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[sv/frame_change_bounding_box.sv]
// ----------------------------------------------------------------------------
// frame_change_bounding_box
// Dirty-rectangle finder: compares each pixel with the stored previous frame
// and reports once per frame the box of all changed pixels or the full frame.
// ----------------------------------------------------------------------------
// Pixels are taken in raster order at one item per clock while in_stall is
// low. Each item reads the frame store (one read port, one write port) in the
// cycle it is taken and is compared and written back in the next, where the
// result of the last pixel is pushed into the output queue. A same-address
// write/read overlap (one pixel frames) is forwarded. Results wait in a
// two-entry output queue; the input stalls only when that queue could not
// hold one more result. No clearing pass is needed: stored pixels are
// compared only after a whole frame of the current size was written.
module frame_change_bounding_box (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [fcbb_pkg::PIX_BITS-1:0]         pixel,
  input  logic                                  force_full,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  changed,
  output logic [fcbb_pkg::X_BITS-1:0]           region_x,
  output logic [fcbb_pkg::Y_BITS-1:0]           region_y,
  output logic [fcbb_pkg::SIZE_BITS-1:0]        region_width,
  output logic [fcbb_pkg::SIZE_BITS-1:0]        region_height,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fcbb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [fcbb_pkg::SIZE_BITS-1:0]        cfg_data
);

  // configuration
  logic [fcbb_pkg::SIZE_BITS-1:0] width_eff;
  logic [fcbb_pkg::SIZE_BITS-1:0] height_eff;
  logic                           cfg_wr;
  logic                           cfg_hit;

  // frame position
  logic [fcbb_pkg::X_BITS-1:0]    col_count;
  logic [fcbb_pkg::Y_BITS-1:0]    line_count;
  logic                           full_pending;
  logic                           accept;
  logic                           last_col;
  logic                           last_item;
  logic [fcbb_pkg::ADDR_BITS-1:0] s0_addr;

  // compare stage
  logic                           s1_valid;
  logic [fcbb_pkg::PIX_BITS-1:0]  s1_pix;
  logic [fcbb_pkg::X_BITS-1:0]    s1_x;
  logic [fcbb_pkg::Y_BITS-1:0]    s1_y;
  logic                           s1_last;
  logic                           s1_full;
  logic                           fwd_hit;
  logic [fcbb_pkg::PIX_BITS-1:0]  fwd_data;
  logic [fcbb_pkg::PIX_BITS-1:0]  rd_data;
  logic [fcbb_pkg::PIX_BITS-1:0]  old_pix;
  logic                           pix_diff;

  // bounds
  logic                           previous_valid;
  logic                           any_change;
  logic [fcbb_pkg::X_BITS-1:0]    least_x;
  logic [fcbb_pkg::X_BITS-1:0]    greatest_x;
  logic [fcbb_pkg::Y_BITS-1:0]    least_y;
  logic [fcbb_pkg::Y_BITS-1:0]    greatest_y;
  logic                           any_change_next;
  logic [fcbb_pkg::X_BITS-1:0]    least_x_next;
  logic [fcbb_pkg::X_BITS-1:0]    greatest_x_next;
  logic [fcbb_pkg::Y_BITS-1:0]    least_y_next;
  logic [fcbb_pkg::Y_BITS-1:0]    greatest_y_next;

  // output queue
  fcbb_pkg::result_t              res_new;
  fcbb_pkg::result_t              out_res;
  fcbb_pkg::result_t              skid_res;
  logic                           skid_valid;
  logic                           push;
  logic                           pop;
  logic [1:0]                     occupancy;

  fcbb_pkg::store_rd_t            store_rd;
  fcbb_pkg::store_wr_t            store_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == fcbb_pkg::REG_FRAME_WIDTH ||
                                cfg_index == fcbb_pkg::REG_FRAME_HEIGHT);

  // input side
  assign pop       = out_valid && !out_stall;
  assign push      = s1_valid && s1_last;
  assign occupancy = 2'(out_valid) + 2'(skid_valid) + 2'(push) - 2'(pop);
  assign in_stall  = (occupancy >= 2'd2);
  assign accept    = in_valid && !in_stall;

  assign last_col  = ({1'b0, col_count} == width_eff - fcbb_pkg::SIZE_BITS'(1));
  assign last_item = last_col &&
                     ({1'b0, line_count} == height_eff - fcbb_pkg::SIZE_BITS'(1));
  assign s0_addr   = {line_count, col_count};

  assign store_rd.en   = accept;
  assign store_rd.addr = s0_addr;
  assign store_wr.en   = s1_valid;
  assign store_wr.addr = {s1_y, s1_x};
  assign store_wr.data = s1_pix;

  fcbb_frame_store u_store (
    .clk     (clk),
    .rd      (store_rd),
    .wr      (store_wr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff      <= fcbb_pkg::RESET_WIDTH;
      height_eff     <= fcbb_pkg::RESET_HEIGHT;
      col_count      <= '0;
      line_count     <= '0;
      full_pending   <= 1'b0;
      s1_valid       <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index == fcbb_pkg::REG_FRAME_WIDTH) begin
        width_eff <= fcbb_pkg::clamp_size(cfg_data, fcbb_pkg::MAX_W_SIZE);
      end else begin
        height_eff <= fcbb_pkg::clamp_size(cfg_data, fcbb_pkg::MAX_H_SIZE);
      end
      col_count    <= '0;
      line_count   <= '0;
      full_pending <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          col_count <= '0;
          if (last_item) begin
            line_count <= '0;
          end else begin
            line_count <= line_count + fcbb_pkg::Y_BITS'(1);
          end
        end else begin
          col_count <= col_count + fcbb_pkg::X_BITS'(1);
        end
        full_pending <= last_item ? 1'b0 : (full_pending || force_full);
      end
    end
  end

  // compare stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel;
      s1_x     <= col_count;
      s1_y     <= line_count;
      s1_last  <= last_item;
      s1_full  <= full_pending || force_full;
      fwd_hit  <= s1_valid && (store_wr.addr == s0_addr);
      fwd_data <= s1_pix;
    end
  end

  assign old_pix  = fwd_hit ? fwd_data : rd_data;
  assign pix_diff = previous_valid && (old_pix != s1_pix);

  always_comb begin
    any_change_next = any_change;
    least_x_next    = least_x;
    greatest_x_next = greatest_x;
    least_y_next    = least_y;
    greatest_y_next = greatest_y;
    if (pix_diff) begin
      any_change_next = 1'b1;
      if (!any_change) begin
        least_x_next    = s1_x;
        greatest_x_next = s1_x;
        least_y_next    = s1_y;
        greatest_y_next = s1_y;
      end else begin
        if (s1_x < least_x)    least_x_next    = s1_x;
        if (s1_x > greatest_x) greatest_x_next = s1_x;
        if (s1_y < least_y)    least_y_next    = s1_y;
        if (s1_y > greatest_y) greatest_y_next = s1_y;
      end
    end
  end

  always_comb begin
    res_new = '0;
    if (!previous_valid || s1_full) begin
      res_new.changed       = 1'b1;
      res_new.region_width  = width_eff;
      res_new.region_height = height_eff;
    end else if (any_change_next) begin
      res_new.changed       = 1'b1;
      res_new.region_x      = least_x_next;
      res_new.region_y      = least_y_next;
      res_new.region_width  = {1'b0, greatest_x_next} - {1'b0, least_x_next}
                              + fcbb_pkg::SIZE_BITS'(1);
      res_new.region_height = {1'b0, greatest_y_next} - {1'b0, least_y_next}
                              + fcbb_pkg::SIZE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      previous_valid <= rst ? 1'b0 : (previous_valid && !cfg_hit);
      any_change     <= 1'b0;
      least_x        <= '1;
      least_y        <= '1;
      greatest_x     <= '0;
      greatest_y     <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        previous_valid <= 1'b1;
        any_change     <= 1'b0;
        least_x        <= '1;
        least_y        <= '1;
        greatest_x     <= '0;
        greatest_y     <= '0;
      end else begin
        any_change     <= any_change_next;
        least_x        <= least_x_next;
        least_y        <= least_y_next;
        greatest_x     <= greatest_x_next;
        greatest_y     <= greatest_y_next;
      end
    end
  end

  // two-entry output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      out_valid  <= 1'b1;
      skid_valid <= out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= skid_valid ? skid_res : res_new;
      if (skid_valid && push) begin
        skid_res <= res_new;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_res <= res_new;
      end else begin
        out_res <= res_new;
      end
    end
  end

  assign changed       = out_res.changed;
  assign region_x      = out_res.region_x;
  assign region_y      = out_res.region_y;
  assign region_width  = out_res.region_width;
  assign region_height = out_res.region_height;

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && out_valid && skid_valid && !pop))
    else $error("result pushed into a full output queue");

  a_position_in_frame: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_count} < width_eff) && ({1'b0, line_count} < height_eff))
    else $error("frame position outside the configured frame");

  a_valid_drop_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(previous_valid) |-> $past(cfg_hit || rst))
    else $error("previous frame discarded without a size write");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_change_bounding_box. Raster-order frames of
// random and hand-picked sizes are fed in bursts while the result side stalls
// on its own pattern. A behavioral model tracks the stored frame and the
// changed-pixel bounds and checks every frame report field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [fcbb_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED_LO =
    fcbb_pkg::CFG_IDX_BITS'(2);
  localparam logic [fcbb_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED_HI =
    fcbb_pkg::CFG_IDX_BITS'(3);
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RAND_ITEMS    = 450;

  typedef struct {
    logic [fcbb_pkg::PIX_BITS-1:0] pix;
    logic                          ff;
  } pixel_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [fcbb_pkg::PIX_BITS-1:0] pixel = '0;
  logic force_full = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic changed;
  logic [fcbb_pkg::X_BITS-1:0] region_x;
  logic [fcbb_pkg::Y_BITS-1:0] region_y;
  logic [fcbb_pkg::SIZE_BITS-1:0] region_width;
  logic [fcbb_pkg::SIZE_BITS-1:0] region_height;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fcbb_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [fcbb_pkg::SIZE_BITS-1:0] cfg_data = '0;

  frame_change_bounding_box dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .force_full(force_full),
    .out_valid(out_valid), .out_stall(out_stall), .changed(changed),
    .region_x(region_x), .region_y(region_y),
    .region_width(region_width), .region_height(region_height),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // model state
  logic [fcbb_pkg::SIZE_BITS-1:0] width_reg;
  logic [fcbb_pkg::SIZE_BITS-1:0] height_reg;
  logic [fcbb_pkg::PIX_BITS-1:0]  stored_frame [int];
  bit                             prev_valid;
  logic [fcbb_pkg::X_BITS-1:0]    col_pos, min_x, max_x;
  logic [fcbb_pkg::Y_BITS-1:0]    line_pos, min_y, max_y;
  bit                             any_diff, full_req;
  fcbb_pkg::result_t              expected_boxes [$];

  // stimulus side
  pixel_item_t                    pending_pixels [$];
  logic [fcbb_pkg::PIX_BITS-1:0]  sent_image [int];
  logic [fcbb_pkg::SIZE_BITS-1:0] gen_width = fcbb_pkg::RESET_WIDTH;
  logic [fcbb_pkg::SIZE_BITS-1:0] gen_height = fcbb_pkg::RESET_HEIGHT;

  int errors = 0;
  int cycle_count = 0;

  function automatic int fit_size(logic [fcbb_pkg::SIZE_BITS-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void restart_scan();
    col_pos = '0;
    line_pos = '0;
    min_x = '1;
    min_y = '1;
    max_x = '0;
    max_y = '0;
    any_diff = 0;
    full_req = 0;
  endfunction

  function automatic void apply_size_write(logic [fcbb_pkg::CFG_IDX_BITS-1:0] idx,
                                           logic [fcbb_pkg::SIZE_BITS-1:0] val);
    if (idx == fcbb_pkg::REG_FRAME_WIDTH) begin
      width_reg = val;
    end else if (idx == fcbb_pkg::REG_FRAME_HEIGHT) begin
      height_reg = val;
    end else begin
      return;
    end
    prev_valid = 0;
    restart_scan();
  endfunction

  function automatic void predict_pixel(logic [fcbb_pkg::PIX_BITS-1:0] pix, logic ff);
    int w, h, c, r, addr;
    logic [fcbb_pkg::PIX_BITS-1:0] old;
    fcbb_pkg::result_t box;
    w = fit_size(width_reg, fcbb_pkg::MAX_WIDTH);
    h = fit_size(height_reg, fcbb_pkg::MAX_HEIGHT);
    c = int'(col_pos);
    r = int'(line_pos);
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    addr = r * fcbb_pkg::MAX_WIDTH + c;
    if (ff) full_req = 1;
    old = stored_frame.exists(addr) ? stored_frame[addr] : '0;
    if (prev_valid && old != pix) begin
      if (!any_diff) begin
        min_x = fcbb_pkg::X_BITS'(c);
        max_x = fcbb_pkg::X_BITS'(c);
        min_y = fcbb_pkg::Y_BITS'(r);
        max_y = fcbb_pkg::Y_BITS'(r);
      end else begin
        if (c < int'(min_x)) min_x = fcbb_pkg::X_BITS'(c);
        if (c > int'(max_x)) max_x = fcbb_pkg::X_BITS'(c);
        if (r < int'(min_y)) min_y = fcbb_pkg::Y_BITS'(r);
        if (r > int'(max_y)) max_y = fcbb_pkg::Y_BITS'(r);
      end
      any_diff = 1;
    end
    stored_frame[addr] = pix;
    if (c + 1 < w) begin
      col_pos = fcbb_pkg::X_BITS'(c + 1);
      return;
    end
    col_pos = '0;
    if (r + 1 < h) begin
      line_pos = fcbb_pkg::Y_BITS'(r + 1);
      return;
    end
    box = '0;
    if (!prev_valid || full_req) begin
      box.changed = 1'b1;
      box.region_width = fcbb_pkg::SIZE_BITS'(w);
      box.region_height = fcbb_pkg::SIZE_BITS'(h);
    end else if (any_diff) begin
      box.changed = 1'b1;
      box.region_x = min_x;
      box.region_y = min_y;
      box.region_width = fcbb_pkg::SIZE_BITS'(int'(max_x) - int'(min_x) + 1);
      box.region_height = fcbb_pkg::SIZE_BITS'(int'(max_y) - int'(min_y) + 1);
    end
    expected_boxes.push_back(box);
    prev_valid = 1;
    restart_scan();
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // driver
  int burst_left = 0;
  int gap_left = 0;
  pixel_item_t next_item;
  logic drive_valid;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      width_reg = fcbb_pkg::RESET_WIDTH;
      height_reg = fcbb_pkg::RESET_HEIGHT;
      prev_valid = 0;
      restart_scan();
    end else begin
      if (cfg_valid && cfg_ready) apply_size_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) predict_pixel(pixel, force_full);
      if (!in_valid || !in_stall) begin
        drive_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pixels.size() > 0) begin
          next_item = pending_pixels.pop_front();
          drive_valid = 1'b1;
          pixel <= next_item.pix;
          force_full <= next_item.ff;
          if (burst_left <= 1) begin
            case ($urandom_range(0, 9))
              0, 1: begin
                burst_left = $urandom_range(50, 300);
                gap_left = 0;
              end
              2: begin
                burst_left = $urandom_range(1, 8);
                gap_left = $urandom_range(20, 30);
              end
              default: begin
                burst_left = $urandom_range(1, 16);
                gap_left = $urandom_range(0, 5);
              end
            endcase
          end else begin
            burst_left--;
          end
        end
        in_valid <= drive_valid;
      end
    end
  end

  // monitor
  int stall_mode = 0;
  int stall_tick = 0;
  int stall_run = 0;
  logic stall_next;
  fcbb_pkg::result_t want_box;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_boxes.size() == 0) begin
          $display("%0t: unexpected result changed %0d x %0d y %0d w %0d h %0d", $time,
                   changed, region_x, region_y, region_width, region_height);
          errors++;
        end else begin
          want_box = expected_boxes.pop_front();
          check_field("changed", want_box.changed, changed);
          check_field("region_x", want_box.region_x, region_x);
          check_field("region_y", want_box.region_y, region_y);
          check_field("region_width", want_box.region_width, region_width);
          check_field("region_height", want_box.region_height, region_height);
        end
      end
      stall_tick++;
      if (stall_tick % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 2) == 0);
        2: stall_next = (stall_tick % 4 != 0);
        default: begin
          if (stall_run == 0) stall_run = $urandom_range(1, 40);
          stall_run--;
          stall_next = (stall_run > 10);
        end
      endcase
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("frame_change_bounding_box verification failed");
      $finish;
    end
  end

  task automatic push_pixel(int addr, logic [fcbb_pkg::PIX_BITS-1:0] pix, logic ff);
    pixel_item_t item;
    item.pix = pix;
    item.ff = ff;
    sent_image[addr] = pix;
    pending_pixels.push_back(item);
  endtask

  task automatic queue_frame(int w, int h, int pct, int ff_pos, int count, bit ends_change);
    int addr;
    logic [fcbb_pkg::PIX_BITS-1:0] old, pix;
    for (int i = 0; i < count; i++) begin
      addr = (i / w) * fcbb_pkg::MAX_WIDTH + (i % w);
      if (sent_image.exists(addr)) begin
        old = sent_image[addr];
        if (ends_change && (i == 0 || i == w * h - 1)) begin
          pix = old ^ (fcbb_pkg::PIX_BITS'(1) << $urandom_range(0, fcbb_pkg::PIX_BITS - 1));
        end else if ($urandom_range(0, 99) < pct) begin
          if ($urandom_range(0, 1) == 0)
            pix = old ^ (fcbb_pkg::PIX_BITS'(1) << $urandom_range(0, 23));
          else pix = fcbb_pkg::PIX_BITS'($urandom);
        end else begin
          pix = old;
        end
      end else begin
        pix = fcbb_pkg::PIX_BITS'($urandom);
      end
      push_pixel(addr, pix, i == ff_pos);
    end
  endtask

  // wait until every queued item is taken and every report has come back
  task automatic settle();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_boxes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size_reg(logic [fcbb_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [fcbb_pkg::SIZE_BITS-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fcbb_pkg::REG_FRAME_WIDTH) gen_width = val;
    else if (idx == fcbb_pkg::REG_FRAME_HEIGHT) gen_height = val;
  endtask

  function automatic logic [fcbb_pkg::SIZE_BITS-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 15) return fcbb_pkg::SIZE_BITS'($urandom_range(9, 24));
    return fcbb_pkg::SIZE_BITS'($urandom_range(1, 8));
  endfunction

  int w, h, n, count, ff_pos, pct, rand_items;
  bit cut_short;

  initial begin
    rand_items = 0;
    cut_short = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // partial frame at the reset size, dropped by the size write
    push_pixel(0, 24'h000000, 1'b0);
    push_pixel(1, 24'hFFFFFF, 1'b0);
    push_pixel(2, 24'hAAAAAA, 1'b1);
    push_pixel(3, 24'h555555, 1'b0);
    push_pixel(4, fcbb_pkg::PIX_BITS'($urandom), 1'b0);
    push_pixel(5, fcbb_pkg::PIX_BITS'($urandom), 1'b0);
    write_size_reg(fcbb_pkg::REG_FRAME_WIDTH, 11'd2);
    write_size_reg(fcbb_pkg::REG_FRAME_HEIGHT, 11'd2);

    // 2x2: first frame full, repeat unchanged, one corner changed, forced full
    push_pixel(0, 24'hFFFFFF, 1'b0);
    push_pixel(1, 24'h000000, 1'b0);
    push_pixel(fcbb_pkg::MAX_WIDTH, 24'h123456, 1'b0);
    push_pixel(fcbb_pkg::MAX_WIDTH + 1, 24'hABCDEF, 1'b0);
    queue_frame(2, 2, 0, -1, 4, 0);
    push_pixel(0, sent_image[0], 1'b0);
    push_pixel(1, sent_image[1], 1'b0);
    push_pixel(fcbb_pkg::MAX_WIDTH, sent_image[fcbb_pkg::MAX_WIDTH], 1'b0);
    push_pixel(fcbb_pkg::MAX_WIDTH + 1, ~sent_image[fcbb_pkg::MAX_WIDTH + 1], 1'b0);
    queue_frame(2, 2, 0, 2, 4, 0);

    // unmapped indexes leave the stored frame valid
    write_size_reg(REG_UNMAPPED_LO, 11'd5);
    write_size_reg(REG_UNMAPPED_HI, 11'h7FF);
    queue_frame(2, 2, 0, -1, 4, 0);

    // zero sizes act as one pixel
    write_size_reg(fcbb_pkg::REG_FRAME_WIDTH, 11'd0);
    write_size_reg(fcbb_pkg::REG_FRAME_HEIGHT, 11'd0);
    queue_frame(1, 1, 0, -1, 1, 0);
    queue_frame(1, 1, 0, -1, 1, 0);
    queue_frame(1, 1, 0, -1, 1, 1);

    // oversize sizes, each frame dropped part way by the next size write
    write_size_reg(fcbb_pkg::REG_FRAME_WIDTH, 11'h7FF);
    write_size_reg(fcbb_pkg::REG_FRAME_HEIGHT, 11'd1);
    queue_frame(fcbb_pkg::MAX_WIDTH, 1, 100, -1, 40, 0);
    write_size_reg(fcbb_pkg::REG_FRAME_WIDTH, 11'd1);
    write_size_reg(fcbb_pkg::REG_FRAME_HEIGHT, 11'd1500);
    queue_frame(1, fcbb_pkg::MAX_HEIGHT, 100, -1, 40, 0);
    write_size_reg(fcbb_pkg::REG_FRAME_HEIGHT, fcbb_pkg::MAX_H_SIZE);

    while (rand_items < RAND_ITEMS) begin
      if (cut_short || fit_size(gen_width, fcbb_pkg::MAX_WIDTH) > 24 ||
          $urandom_range(0, 2) != 0)
        write_size_reg(fcbb_pkg::REG_FRAME_WIDTH, pick_dim());
      if (fit_size(gen_height, fcbb_pkg::MAX_HEIGHT) > 24 || $urandom_range(0, 2) != 0)
        write_size_reg(fcbb_pkg::REG_FRAME_HEIGHT, pick_dim());
      cut_short = 0;
      w = fit_size(gen_width, fcbb_pkg::MAX_WIDTH);
      h = fit_size(gen_height, fcbb_pkg::MAX_HEIGHT);
      n = $urandom_range(2, 5);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 5) == 0) settle();
        if ($urandom_range(0, 9) == 0)
          write_size_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                         fcbb_pkg::SIZE_BITS'($urandom));
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 5;
          2: pct = 30;
          default: pct = 100;
        endcase
        count = w * h;
        if (k == n - 1 && count > 1 && $urandom_range(0, 9) == 0) begin
          count = $urandom_range(1, count - 1);
          cut_short = 1;
        end
        ff_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : -1;
        queue_frame(w, h, pct, ff_pos, count, $urandom_range(0, 3) == 0);
        rand_items += count;
      end
    end

    settle();
    if (errors == 0 && expected_boxes.size() == 0) begin
      $display("frame_change_bounding_box verification clean");
    end else begin
      $display("frame_change_bounding_box verification failed");
    end
    $finish;
  end

endmodule
